[hdl/lzw_encoder_fixed_width_top_defines.svh]
// Assertion macros used by the verification file of the LZW encoder.
`ifndef LZW_ENCODER_FIXED_WIDTH_TOP_DEFINES_SVH
`define LZW_ENCODER_FIXED_WIDTH_TOP_DEFINES_SVH

// Check that a condition holds at every clock edge outside reset.
`define LZWE_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger implies a consequence in the following cycle.
`define LZWE_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

[hdl/lzwe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwe_pkg
// Types and constants shared by the fixed-width LZW encoder modules.
// ----------------------------------------------------------------------------
package lzwe_pkg;

    localparam int CODE_W = 16;
    localparam int ROOTS = 256;
    localparam logic [7:0] KEY_FLIP = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last_code;
    } out_item_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] key;
        logic       last;
    } eng_in_t;

    typedef struct packed {
        logic      push0;
        out_item_t item0;
        logic      push1;
        out_item_t item1;
    } out_push_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_ROOT,
        ENG_WALK,
        ENG_NEW
    } eng_state_t;

endpackage

[hdl/lzwe_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/lzwe_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwe_front
// Input side: accepts bytes, turns them into tree keys, queues two items.
// ----------------------------------------------------------------------------
module lzwe_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  lzwe_pkg::in_item_t in_item,
    output lzwe_pkg::eng_in_t  eng_in,
    input  logic               eng_pop
);

    logic [8:0] slot_reg [2];
    logic       wptr_reg;
    logic       wptr_next;
    logic       rptr_reg;
    logic       rptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full    = (count_reg == 2'd2);
    assign do_push = push && !full;
    assign do_pop  = eng_pop && (count_reg != 2'd0);

    assign eng_in.valid = (count_reg != 2'd0);
    assign eng_in.key   = slot_reg[rptr_reg][8:1];
    assign eng_in.last  = slot_reg[rptr_reg][0];

    always_comb
    begin
        wptr_next  = wptr_reg ^ do_push;
        rptr_next  = rptr_reg ^ do_pop;
        count_next = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= {in_item.data_byte ^ lzwe_pkg::KEY_FLIP, in_item.last_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

[hdl/lzwe_out_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwe_out_queue
// Four-entry result queue, up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module lzwe_out_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  lzwe_pkg::out_push_t wr,
    output logic                room2,
    output logic                empty,
    input  logic                pop,
    output lzwe_pkg::out_item_t out_item
);

    lzwe_pkg::out_item_t slot_reg [4];
    logic [1:0] wptr_reg;
    logic [1:0] wptr_next;
    logic [1:0] rptr_reg;
    logic [1:0] rptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       do_pop;
    logic [1:0] waddr1;

    assign empty    = (count_reg == 3'd0);
    assign room2    = (count_reg <= 3'd2);
    assign do_pop   = pop && !empty;
    assign out_item = slot_reg[rptr_reg];
    assign waddr1   = wptr_reg + {1'b0, wr.push0};

    always_comb
    begin
        wptr_next  = wptr_reg + {1'b0, wr.push0} + {1'b0, wr.push1};
        rptr_next  = rptr_reg + {1'b0, do_pop};
        count_next = count_reg + {2'b0, wr.push0} + {2'b0, wr.push1} - {2'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (wr.push0)
        begin
            slot_reg[wptr_reg] <= wr.item0;
        end
        if (wr.push1)
        begin
            slot_reg[waddr1] <= wr.item1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 2'd0;
            rptr_reg  <= 2'd0;
            count_reg <= 3'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

[hdl/lzwe_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwe_engine
// Dictionary walk: looks up (prefix, key) in the child search tree,
// inserts missing strings and emits codes.
// ----------------------------------------------------------------------------
module lzwe_engine #(
    parameter int CODE_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lzwe_pkg::eng_in_t   eng_in,
    output logic                eng_pop,
    input  logic                room2,
    output lzwe_pkg::out_push_t wr
);

    localparam int CW = CODE_BITS;
    localparam int NW = 3 * CW + 8;
    localparam logic [CW-1:0] NO_CODE = {CW{1'b1}};
    localparam logic [CW-1:0] ROOT_CODES = CW'(lzwe_pkg::ROOTS);

    lzwe_pkg::eng_state_t state_reg;
    lzwe_pkg::eng_state_t state_next;
    logic [CW-1:0]  prefix_reg;
    logic [CW-1:0]  prefix_next;
    logic           prefix_valid_reg;
    logic           prefix_valid_next;
    logic [CW-1:0]  nfc_reg;
    logic [CW-1:0]  nfc_next;
    logic [CW-1:0]  cur_reg;
    logic [CW-1:0]  cur_next;
    logic [7:0]     key_reg;
    logic [7:0]     key_next;
    logic           last_reg;
    logic           last_next;
    logic [255:0]   root_valid_reg;
    logic [255:0]   root_valid_next;

    logic           ram_we;
    logic [CW-1:0]  ram_waddr;
    logic [NW-1:0]  ram_wdata;
    logic [CW-1:0]  ram_raddr;
    logic [NW-1:0]  ram_rdata;

    logic [CW-1:0]  rd_first;
    logic [CW-1:0]  rd_left;
    logic [CW-1:0]  rd_right;
    logic [7:0]     rd_key;
    logic           prefix_is_root;
    logic [CW-1:0]  first_code;
    logic           take;
    logic           go_left;
    logic           go_right;
    logic           fin;
    logic           fin_last;
    logic [CW-1:0]  fin_prefix;
    logic [CW-1:0]  key_code;
    logic [CW-1:0]  in_code;

    lzwe_ram #(
        .WIDTH(NW),
        .DEPTH(1 << CW)
    ) u_tree (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_first = ram_rdata[NW-1 -: CW];
    assign rd_left  = ram_rdata[2*CW+7 -: CW];
    assign rd_right = ram_rdata[CW+7 -: CW];
    assign rd_key   = ram_rdata[7:0];

    assign prefix_is_root = (prefix_reg < ROOT_CODES);
    // Roots that were cleared read as childless.
    assign first_code = (prefix_is_root && !root_valid_reg[prefix_reg[7:0]]) ? NO_CODE
                                                                             : rd_first;
    assign take     = eng_in.valid && room2;
    assign go_left  = (key_reg < rd_key);
    assign go_right = (key_reg > rd_key);
    assign key_code = {{(CW-8){1'b0}}, key_reg};
    assign in_code  = {{(CW-8){1'b0}}, eng_in.key};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lzwe_pkg::ENG_IDLE:
            begin
                if (take && prefix_valid_reg)
                begin
                    state_next = lzwe_pkg::ENG_ROOT;
                end
            end
            lzwe_pkg::ENG_ROOT:
            begin
                state_next = (first_code == NO_CODE) ? lzwe_pkg::ENG_NEW : lzwe_pkg::ENG_WALK;
            end
            lzwe_pkg::ENG_WALK:
            begin
                priority if (go_left)
                begin
                    if (rd_left == NO_CODE)
                    begin
                        state_next = lzwe_pkg::ENG_NEW;
                    end
                end
                else if (go_right)
                begin
                    if (rd_right == NO_CODE)
                    begin
                        state_next = lzwe_pkg::ENG_NEW;
                    end
                end
                else
                begin
                    state_next = lzwe_pkg::ENG_IDLE;
                end
            end
            lzwe_pkg::ENG_NEW:
            begin
                state_next = lzwe_pkg::ENG_IDLE;
            end
            default:
            begin
                state_next = lzwe_pkg::ENG_IDLE;
            end
        endcase
    end

    always_comb
    begin
        prefix_next       = prefix_reg;
        prefix_valid_next = prefix_valid_reg;
        nfc_next          = nfc_reg;
        cur_next          = cur_reg;
        key_next          = key_reg;
        last_next         = last_reg;
        root_valid_next   = root_valid_reg;
        ram_we            = 1'b0;
        ram_waddr         = nfc_reg;
        ram_wdata         = {NO_CODE, NO_CODE, NO_CODE, key_reg};
        ram_raddr         = prefix_reg;
        eng_pop           = 1'b0;
        wr                = '0;
        fin               = 1'b0;
        fin_last          = last_reg;
        fin_prefix        = key_code;

        unique case (state_reg)
            lzwe_pkg::ENG_IDLE:
            begin
                if (take)
                begin
                    eng_pop   = 1'b1;
                    key_next  = eng_in.key;
                    last_next = eng_in.last;
                    // Fall back to the roots once the dictionary is full.
                    if (nfc_reg == NO_CODE)
                    begin
                        root_valid_next = '0;
                        nfc_next        = ROOT_CODES;
                    end
                    if (!prefix_valid_reg)
                    begin
                        prefix_next       = in_code;
                        prefix_valid_next = 1'b1;
                        fin               = 1'b1;
                        fin_last          = eng_in.last;
                        fin_prefix        = in_code;
                    end
                end
            end
            lzwe_pkg::ENG_ROOT:
            begin
                if (first_code == NO_CODE)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = prefix_reg;
                    ram_wdata = {nfc_reg, ram_rdata[2*CW+7:0]};
                    if (prefix_is_root)
                    begin
                        root_valid_next[prefix_reg[7:0]] = 1'b1;
                    end
                end
                else
                begin
                    cur_next  = first_code;
                    ram_raddr = first_code;
                end
            end
            lzwe_pkg::ENG_WALK:
            begin
                priority if (go_left)
                begin
                    if (rd_left == NO_CODE)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = cur_reg;
                        ram_wdata = {rd_first, nfc_reg, rd_right, rd_key};
                    end
                    else
                    begin
                        cur_next  = rd_left;
                        ram_raddr = rd_left;
                    end
                end
                else if (go_right)
                begin
                    if (rd_right == NO_CODE)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = cur_reg;
                        ram_wdata = {rd_first, rd_left, nfc_reg, rd_key};
                    end
                    else
                    begin
                        cur_next  = rd_right;
                        ram_raddr = rd_right;
                    end
                end
                else
                begin
                    prefix_next = cur_reg;
                    fin         = 1'b1;
                    fin_prefix  = cur_reg;
                end
            end
            lzwe_pkg::ENG_NEW:
            begin
                ram_we              = 1'b1;
                wr.push0            = 1'b1;
                wr.item0.code       = lzwe_pkg::CODE_W'(prefix_reg);
                wr.item0.last_code  = 1'b0;
                prefix_next         = key_code;
                nfc_next            = nfc_reg + 1'b1;
                fin                 = 1'b1;
            end
            default:
            begin
                fin = 1'b0;
            end
        endcase

        // End of block: flush the prefix and drop back to the reset state.
        if (fin && fin_last)
        begin
            wr.push1           = 1'b1;
            wr.item1.code      = lzwe_pkg::CODE_W'(fin_prefix);
            wr.item1.last_code = 1'b1;
            prefix_valid_next  = 1'b0;
            root_valid_next    = '0;
            nfc_next           = ROOT_CODES;
        end
    end

    always_ff @(posedge clk)
    begin
        prefix_reg <= prefix_next;
        cur_reg    <= cur_next;
        key_reg    <= key_next;
        last_reg   <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= lzwe_pkg::ENG_IDLE;
            prefix_valid_reg <= 1'b0;
            nfc_reg          <= ROOT_CODES;
            root_valid_reg   <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            prefix_valid_reg <= prefix_valid_next;
            nfc_reg          <= nfc_next;
            root_valid_reg   <= root_valid_next;
        end
    end

endmodule

[hdl/lzw_encoder_fixed_width_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_encoder_fixed_width_top
// Fixed-width LZW encoder: bytes in, dictionary codes out.
//
//   channel  | handshake     | payload
//   ---------+---------------+--------------------------------
//   input    | push / full   | in_item  (data_byte, last_byte)
//   result   | pop / empty   | out_item (code, last_code)
//
// An item that starts a block is done in the idle state; any other passes idle,
// root, walk once per tree node visited, and new when the string is inserted;
// nodes are visited one per cycle through the registered read port of the RAM.
// No clearing pass: the 256 roots carry valid bits that reset clears at once.
// Two input items and four results are buffered; the engine takes an item
// only while the result queue has room for two results.
// ----------------------------------------------------------------------------
module lzw_encoder_fixed_width_top #(
    parameter int CODE_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  lzwe_pkg::in_item_t  in_item,
    output logic                empty,
    input  logic                pop,
    output lzwe_pkg::out_item_t out_item
);

    lzwe_pkg::eng_in_t   eng_in;
    lzwe_pkg::out_push_t wr;
    logic                eng_pop;
    logic                room2;

    lzwe_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .in_item(in_item),
        .eng_in (eng_in),
        .eng_pop(eng_pop)
    );

    lzwe_engine #(
        .CODE_BITS(CODE_BITS)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .eng_in (eng_in),
        .eng_pop(eng_pop),
        .room2  (room2),
        .wr     (wr)
    );

    lzwe_out_queue u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .room2   (room2),
        .empty   (empty),
        .pop     (pop),
        .out_item(out_item)
    );

endmodule

[hdl/lzwe_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwe_checker
// Port-level checks for the LZW encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "lzw_encoder_fixed_width_top_defines.svh"

module lzwe_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                push,
    input logic                full,
    input lzwe_pkg::in_item_t  in_item,
    input logic                empty,
    input logic                pop,
    input lzwe_pkg::out_item_t out_item
);

    logic seen_reg;

    // Remember whether any item has entered since reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else if (push && !full)
        begin
            seen_reg <= 1'b1;
        end
    end

    `LZWE_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_item), "result changed while waiting")
    `LZWE_ASSERT_ALWAYS(a_code_range, clk, rst_n, empty || (out_item.code != 16'hffff), "code out of range")
    `LZWE_ASSERT_ALWAYS(a_no_invent, clk, rst_n, empty || seen_reg, "result before any item")

endmodule

bind lzw_encoder_fixed_width_top lzwe_checker u_lzwe_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item)
);
